FILE: rtl/pbts_pkg.sv
// ----------------------------------------------------------------------------
// pbts_pkg
// Types and codes shared by the per-book trade statistics table.
// ----------------------------------------------------------------------------
`default_nettype none

package pbts_pkg;

  localparam logic KIND_RECORD  = 1'b0;
  localparam logic KIND_RESTORE = 1'b1;

  typedef struct packed {
    logic               kind;
    logic [9:0]         book;
    logic signed [31:0] price;
    logic [31:0]        qty;
    logic [63:0]        match_id;
    logic signed [31:0] base_px;
    logic [63:0]        restore_trades;
    logic [63:0]        restore_volume;
    logic [63:0]        restore_notional;
  } in_item_t;

  typedef struct packed {
    logic [9:0]         book_out;
    logic [63:0]        book_trades;
    logic [63:0]        book_volume;
    logic [63:0]        book_notional;
    logic signed [31:0] last_px;
    logic [31:0]        last_quantity;
    logic [63:0]        last_match;
    logic               has_traded;
    logic               uptick_flag;
    logic [63:0]        total_trades;
    logic [63:0]        total_volume_out;
  } out_item_t;

  // Classified item handed from the front queue to the back end.
  typedef struct packed {
    in_item_t item;
    logic     in_range;
  } job_t;

  // Handshake between front and back.
  typedef struct packed {
    logic valid;
  } front_stat_t;

  // One table entry as held in the memory.
  typedef struct packed {
    logic [63:0]        trades;
    logic [63:0]        volume;
    logic [63:0]        notional;
    logic signed [31:0] prev_px;
    logic [31:0]        prev_qty;
    logic [63:0]        last_match;
    logic               traded;
    logic               uptick;
  } entry_t;

endpackage

`default_nettype wire

FILE: rtl/pbts_front.sv
// ----------------------------------------------------------------------------
// pbts_front
// Input side: accept items, check the book index, hold them in a
// two-entry queue for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module pbts_front
  import pbts_pkg::*;
#(
  parameter int NUM_BOOKS = 1024
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  output logic          full,
  input  wire in_item_t in_item,
  input  wire logic     clearing,
  input  wire logic     take,
  output front_stat_t   stat,
  output job_t          job
);

  job_t       q_r [2];
  logic [1:0] cnt_r;
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic       push_ok;
  logic       pop_ok;
  job_t       job_in;

  assign full   = (cnt_r == 2'd2) || clearing;
  assign push_ok = push && !full;
  assign pop_ok  = take && (cnt_r != 2'd0);

  always_comb begin
    job_in.item     = in_item;
    job_in.in_range = (32'(in_item.book) < 32'(NUM_BOOKS));
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      q_r[wr_ptr_r] <= job_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= 2'd0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      if (push_ok) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop_ok) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (push_ok && !pop_ok) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (pop_ok && !push_ok) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  assign job            = q_r[rd_ptr_r];
  assign stat.valid     = (cnt_r != 2'd0);

endmodule

`default_nettype wire

FILE: rtl/pbts_back.sv
// ----------------------------------------------------------------------------
// pbts_back
// Back end: clear the table after reset, then run each item through a
// read-modify-write of its entry and update the global totals.
// ----------------------------------------------------------------------------
`default_nettype none

module pbts_back
  import pbts_pkg::*;
#(
  parameter int NUM_BOOKS = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire front_stat_t stat,
  input  wire job_t        job,
  output logic             take,
  output logic             clearing,
  output logic             empty,
  input  wire logic        pop,
  output out_item_t        out_item
);

  localparam int AW = (NUM_BOOKS > 1) ? $clog2(NUM_BOOKS) : 1;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_MUL   = 3'd3;
  localparam logic [2:0] S_ADJ   = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  entry_t      mem [NUM_BOOKS];

  logic [2:0]  state_r, state_nxt;
  logic [AW-1:0] clr_cnt_r;
  job_t        cur_r;
  entry_t      rd_data_r;
  logic [63:0] prod_r;
  logic [63:0] d_trades_r;
  logic [63:0] d_volume_r;
  logic [63:0] d_notional_r;
  logic [63:0] grand_trades_r;
  logic [63:0] grand_volume_r;
  logic        out_valid_r;
  out_item_t   out_r;
  out_item_t   out_nxt;

  logic [AW-1:0] addr;
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  entry_t        mem_wd;
  entry_t        new_entry;
  logic signed [31:0] ref_px;
  logic          slot_free;
  logic          finish;
  logic [63:0]   corr;

  assign addr      = AW'(cur_r.item.book);
  assign slot_free = !out_valid_r || pop;
  assign finish    = (state_r == S_DONE) && slot_free;
  assign take      = (state_r == S_IDLE) && stat.valid;
  assign clearing  = (state_r == S_CLEAR);
  assign empty     = !out_valid_r;
  assign out_item  = out_r;

  // Sign correction: a negative price adds a spurious q * 2^32 modulo 2^64.
  assign corr = cur_r.item.price[31] ? {cur_r.item.qty, 32'd0} : 64'd0;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (clr_cnt_r == AW'(NUM_BOOKS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (stat.valid) begin
          state_nxt = S_READ;
        end
      end
      S_READ:  state_nxt = S_MUL;
      S_MUL:   state_nxt = S_ADJ;
      S_ADJ:   state_nxt = S_DONE;
      S_DONE: begin
        if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // New entry contents for the item in hand.
  always_comb begin
    new_entry = rd_data_r;
    ref_px    = rd_data_r.traded ? rd_data_r.prev_px : cur_r.item.base_px;
    if (cur_r.item.kind == KIND_RECORD) begin
      new_entry.trades   = rd_data_r.trades + d_trades_r;
      new_entry.volume   = rd_data_r.volume + d_volume_r;
      new_entry.notional = rd_data_r.notional + d_notional_r;
      if (!ref_px[31]) begin
        if (cur_r.item.price > ref_px) begin
          new_entry.uptick = 1'b1;
        end else if (cur_r.item.price < ref_px) begin
          new_entry.uptick = 1'b0;
        end
      end
      new_entry.traded = 1'b1;
    end else begin
      new_entry.trades   = cur_r.item.restore_trades;
      new_entry.volume   = cur_r.item.restore_volume;
      new_entry.notional = cur_r.item.restore_notional;
      new_entry.traded   = !cur_r.item.price[31];
      new_entry.uptick   = 1'b0;
    end
    new_entry.prev_px    = cur_r.item.price;
    new_entry.prev_qty   = cur_r.item.qty;
    new_entry.last_match = cur_r.item.match_id;
  end

  // Result for the item in hand; out-of-range books report zeros and the
  // current totals.
  always_comb begin
    out_nxt          = '0;
    out_nxt.book_out = cur_r.item.book;
    if (cur_r.in_range) begin
      out_nxt.book_trades      = new_entry.trades;
      out_nxt.book_volume      = new_entry.volume;
      out_nxt.book_notional    = new_entry.notional;
      out_nxt.last_px          = new_entry.prev_px;
      out_nxt.last_quantity    = new_entry.prev_qty;
      out_nxt.last_match       = new_entry.last_match;
      out_nxt.has_traded       = new_entry.traded;
      out_nxt.uptick_flag      = new_entry.uptick;
      out_nxt.total_trades     = grand_trades_r + d_trades_r;
      out_nxt.total_volume_out = grand_volume_r + d_volume_r;
    end else begin
      out_nxt.total_trades     = grand_trades_r;
      out_nxt.total_volume_out = grand_volume_r;
    end
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = addr;
    mem_wd = new_entry;
    if (state_r == S_CLEAR) begin
      mem_we = 1'b1;
      mem_wa = clr_cnt_r;
      mem_wd = '0;
    end else if (finish && cur_r.in_range) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (state_r == S_READ) begin
      rd_data_r <= mem[addr];
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (take) begin
      cur_r <= job;
    end
    if (state_r == S_MUL) begin
      prod_r <= {32'd0, cur_r.item.price} * {32'd0, cur_r.item.qty};
    end
    if (state_r == S_ADJ) begin
      if (cur_r.item.kind == KIND_RECORD) begin
        d_trades_r <= 64'd1;
        d_volume_r <= {32'd0, cur_r.item.qty};
      end else begin
        d_trades_r <= cur_r.item.restore_trades - rd_data_r.trades;
        d_volume_r <= cur_r.item.restore_volume - rd_data_r.volume;
      end
      d_notional_r <= prod_r - corr;
    end
    if (finish) begin
      out_r <= out_nxt;
    end
  end

  // Control state and totals.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_CLEAR;
      clr_cnt_r      <= '0;
      grand_trades_r <= 64'd0;
      grand_volume_r <= 64'd0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + AW'(1);
      end
      if (finish && cur_r.in_range) begin
        grand_trades_r <= grand_trades_r + d_trades_r;
        grand_volume_r <= grand_volume_r + d_volume_r;
      end
      if (finish) begin
        out_valid_r <= 1'b1;
      end else if (pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/per_book_trade_stats_table.sv
// ----------------------------------------------------------------------------
// per_book_trade_stats_table
// Per-book trade statistics with global totals, one entry per book index.
// ----------------------------------------------------------------------------
// Path: a transfer waits in the front queue; the back end then takes it
//   through the read, multiply, adjust and write-back steps of the single
//   memory port, one item at a time; write-back waits for a free result slot.
// Reset: synchronous; afterwards the table is swept to zero, one entry a
//   cycle from index 0 to NUM_BOOKS-1, with full held high throughout.
`default_nettype none

module per_book_trade_stats_table
  import pbts_pkg::*;
#(
  parameter int NUM_BOOKS = 1024
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  // input queue side
  input  wire logic      push,
  output logic           full,
  input  wire in_item_t  in_item,
  // result queue side
  output logic           empty,
  input  wire logic      pop,
  output out_item_t      out_item
);

  front_stat_t stat;
  job_t        job;
  logic        take;
  logic        clearing;

  // Front: accept and classify each transfer, hold it until the back end
  // is ready for it.
  pbts_front #(
    .NUM_BOOKS (NUM_BOOKS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_item  (in_item),
    .clearing (clearing),
    .take     (take),
    .stat     (stat),
    .job      (job)
  );

  // Back: clear the table, then update one entry per in-range item and
  // advance the totals; the result waits in an output register until popped.
  pbts_back #(
    .NUM_BOOKS (NUM_BOOKS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .stat     (stat),
    .job      (job),
    .take     (take),
    .clearing (clearing),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
  );

endmodule

`default_nettype wire
